@@ rtl/feedback_keystream_byte_cipher_top_defines.svh @@
// Assertion macros shared by the cipher RTL.
`ifndef FEEDBACK_KEYSTREAM_BYTE_CIPHER_TOP_DEFINES_SVH
`define FEEDBACK_KEYSTREAM_BYTE_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define FKBC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (prop)) else $error(msg);

`define FKBC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define FKBC_ASSERT(lbl, clk_s, rst_s, prop, msg)

`define FKBC_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

@@ rtl/fkbc_pkg.sv @@
package fkbc_pkg;

  localparam int KEY_LENGTH_DEF = 20;
  localparam int KEY_POS_W      = 5;
  localparam int KEY_TABLE_LEN  = 32;

  localparam logic CFG_IDX_ENABLE  = 1'b0;
  localparam logic CFG_IDX_DECRYPT = 1'b1;

  localparam logic [7:0] KEY_CHARS [KEY_TABLE_LEN] = '{
    8'h55, 8'h6a, 8'h63, 8'h67, 8'h6a, 8'h6c, 8'h62, 8'h43,
    8'h67, 8'h66, 8'h63, 8'h62, 8'h42, 8'h43, 8'h6a, 8'h5b,
    8'h68, 8'h66, 8'h79, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_t;

endpackage

@@ rtl/feedback_keystream_byte_cipher_top.sv @@
// Byte-wide stream cipher with ciphertext feedback.
// Input requests arrive on in_valid/in_ready with in_data carrying one byte
// and a last-of-message flag. Results leave on out_valid/out_ready with the
// transformed byte and a copy of the flag, one result per request, in order.
// A request passes through an input register and then the cipher logic,
// which loads the result register, from which the result leaves when
// out_ready is high. One request is accepted every cycle while out_ready
// is high; the single feedback update of the key state between the input
// and result registers sets that rate.
// The configuration port takes a write on any cycle with cfg_we high:
// index 0 is the enable (1 ciphers, 0 passes bytes through) and index 1 is
// the decrypt mode (1 feeds back input bytes, 0 feeds back output bytes).
// Write it only while no request is in flight.
// A synchronous reset on rst_n empties both registers, restores the key
// state and sets the enable to 1 and the decrypt mode to 0.
// When the receiver holds out_ready low, the result register holds its
// request, the input register fills and then in_ready drops; nothing is lost.
// After a request with the last flag set, the key state returns to its
// reset values for the next message.
`include "feedback_keystream_byte_cipher_top_defines.svh"

module feedback_keystream_byte_cipher_top
  import fkbc_pkg::*;
#(
  parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data,
  input  logic  cfg_we,
  input  logic  cfg_index,
  input  logic  cfg_wdata
);

  logic                 enable_r;
  logic                 decrypt_r;
  logic                 s1_valid_r;
  in_t                  s1_data_r;
  logic                 out_valid_r;
  out_t                 out_data_r;
  logic [7:0]           key_r, key_nxt;
  logic [7:0]           step_r, step_nxt;
  logic [KEY_POS_W-1:0] kpos_r, kpos_nxt;
  logic [7:0]           prior_r, prior_nxt;
  logic [7:0]           earlier_r, earlier_nxt;
  logic                 s1_adv;
  logic [7:0]           key_step;
  logic [7:0]           key_mix;
  logic [7:0]           cipher_byte;
  logic [7:0]           result_byte;
  logic [KEY_POS_W:0]   kpos_inc;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (step_r[0]) begin
      key_step = key_r + step_r;
      key_mix  = key_step + (prior_r - earlier_r);
    end else begin
      key_step = key_r - step_r;
      key_mix  = key_step ^ (prior_r + earlier_r);
    end
    cipher_byte = s1_data_r.data_byte ^ key_mix ^ KEY_CHARS[kpos_r];
    result_byte = enable_r ? cipher_byte : s1_data_r.data_byte;
    kpos_inc    = {1'b0, kpos_r} + (KEY_POS_W + 1)'(1);

    key_nxt     = key_r;
    step_nxt    = step_r;
    kpos_nxt    = kpos_r;
    prior_nxt   = prior_r;
    earlier_nxt = earlier_r;
    if (s1_adv) begin
      if (enable_r) begin
        key_nxt     = key_mix;
        step_nxt    = step_r + 8'd1;
        kpos_nxt    = (kpos_inc >= (KEY_POS_W + 1)'(KEY_LENGTH)) ? '0
                                                                 : kpos_inc[KEY_POS_W-1:0];
        earlier_nxt = prior_r;
        prior_nxt   = decrypt_r ? s1_data_r.data_byte : cipher_byte;
      end
      if (s1_data_r.last_of_message) begin
        key_nxt     = 8'd0;
        step_nxt    = 8'd1;
        kpos_nxt    = '0;
        prior_nxt   = 8'd0;
        earlier_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      decrypt_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= 8'd0;
      step_r      <= 8'd1;
      kpos_r      <= '0;
      prior_r     <= 8'd0;
      earlier_r   <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_ENABLE:  enable_r  <= cfg_wdata;
          CFG_IDX_DECRYPT: decrypt_r <= cfg_wdata;
          default:         enable_r  <= enable_r;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      key_r     <= key_nxt;
      step_r    <= step_nxt;
      kpos_r    <= kpos_nxt;
      prior_r   <= prior_nxt;
      earlier_r <= earlier_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r.result_byte <= result_byte;
      out_data_r.result_last <= s1_data_r.last_of_message;
    end
  end

  `FKBC_ASSERT(a_last_clears, clk, rst_n,
    (s1_adv && s1_data_r.last_of_message) |=> (key_r == 8'd0 && step_r == 8'd1 &&
    kpos_r == '0 && prior_r == 8'd0 && earlier_r == 8'd0),
    "State not cleared after last byte")
  `FKBC_ASSERT(a_kpos_range, clk, rst_n,
    ({1'b0, kpos_r} < (KEY_POS_W + 1)'(KEY_LENGTH)), "Key position out of range")
  `FKBC_ASSERT(a_step_advance, clk, rst_n,
    (s1_adv && enable_r && !s1_data_r.last_of_message) |=>
    (step_r == 8'($past(step_r) + 8'd1)), "Step counter did not advance")
  `FKBC_ASSERT(a_bypass, clk, rst_n,
    (s1_adv && !enable_r && !s1_data_r.last_of_message) |=>
    (out_data_r.result_byte == $past(s1_data_r.data_byte) && key_r == $past(key_r)),
    "Bypass altered byte or state")
  `FKBC_ASSERT_ALWAYS(a_empty_ready, clk, (!s1_valid_r |-> in_ready),
    "Empty input register not ready")

endmodule

@@ sim/cipher_stream_checker.sv @@
`timescale 1ns / 1ps

module cipher_stream_checker
  import fkbc_pkg::*;
#(
  parameter int KEY_LEN = 20
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   pending
);

  localparam logic [159:0] KEY_TEXT = "UjcgjlbCgfcbBCj[hfyb";

  logic       enabled;
  logic       decrypting;
  logic [7:0] key_acc;
  logic [7:0] step_cnt;
  logic [7:0] fb_prior;
  logic [7:0] fb_earlier;
  logic [4:0] key_idx;
  out_t       cipher_bytes_q[$];
  int         fails;

  function automatic logic [7:0] key_char(logic [4:0] idx);
    if (int'(idx) >= 20) return 8'h00;
    return KEY_TEXT[159 - 8 * int'(idx) -: 8];
  endfunction

  function void restart_message();
    key_acc    = 8'h00;
    step_cnt   = 8'h01;
    key_idx    = 5'd0;
    fb_prior   = 8'h00;
    fb_earlier = 8'h00;
  endfunction

  function out_t cipher_byte(in_t req);
    logic [7:0] k;
    logic [7:0] fb_sum;
    logic [7:0] fb_diff;
    logic [7:0] res;
    int         nxt;
    out_t       o;
    res = req.data_byte;
    if (enabled) begin
      fb_sum  = fb_prior + fb_earlier;
      fb_diff = fb_prior - fb_earlier;
      if (step_cnt[0]) begin
        k = key_acc + step_cnt;
        k = k + fb_diff;
      end else begin
        k = key_acc - step_cnt;
        k = k ^ fb_sum;
      end
      res        = req.data_byte ^ (k ^ key_char(key_idx));
      fb_earlier = fb_prior;
      fb_prior   = decrypting ? req.data_byte : res;
      key_acc    = k;
      step_cnt   = step_cnt + 8'd1;
      nxt        = int'(key_idx) + 1;
      if (nxt >= KEY_LEN) nxt = 0;
      key_idx = 5'(nxt);
    end
    if (req.last_of_message) restart_message();
    o.result_byte = res;
    o.result_last = req.last_of_message;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (!rst_n) begin
      enabled    = 1'b1;
      decrypting = 1'b0;
      restart_message();
      cipher_bytes_q.delete();
      fails = 0;
    end else begin
      // Results are retired before new requests are predicted so that a
      // spurious result can never match a request accepted at the same edge.
      if (out_valid && out_ready) begin
        got = out_data;
        if (cipher_bytes_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] Unexpected result: byte %02h last %0b", $realtime,
                     got.result_byte, got.result_last);
        end else begin
          want = cipher_bytes_q.pop_front();
          if (got.result_byte !== want.result_byte ||
              got.result_last !== want.result_last) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] Wrong result: expected byte %02h last %0b, got byte %02h last %0b",
                       $realtime, want.result_byte, want.result_last,
                       got.result_byte, got.result_last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_ENABLE) begin
          enabled = cfg_wdata;
        end else if (cfg_index == CFG_IDX_DECRYPT) begin
          decrypting = cfg_wdata;
        end
      end
      if (in_valid && in_ready) cipher_bytes_q.push_back(cipher_byte(in_data));
    end
    fail_count <= fails;
    pending    <= cipher_bytes_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb
  import fkbc_pkg::*;
();

  localparam int KEY_LEN      = 20;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 800000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we    = 1'b0;
  logic cfg_index = CFG_IDX_ENABLE;
  logic cfg_wdata = 1'b0;

  int fail_count;
  int pending;
  int cycles = 0;
  int sent = 0;
  int messages = 0;
  int settings_used = 0;
  int cur_len = 0;
  int longest = 0;
  bit steady = 1'b0;
  int stall_left = 0;

  always #5 clk = ~clk;

  feedback_keystream_byte_cipher_top #(.KEY_LENGTH(KEY_LEN)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cipher_stream_checker #(.KEY_LEN(KEY_LEN)) stream_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Unless steady is set, the receiver stalls in short bursts and now and then for a long stretch.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      stall_left = 0;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    cur_len++;
    if (cur_len > longest) longest = cur_len;
    if (last) begin
      messages++;
      cur_len = 0;
    end
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_setting(logic en, logic dec);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_ENABLE;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_index <= CFG_IDX_DECRYPT;
    cfg_wdata <= dec;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    int rnd_start;
    int phase_len;
    int msg_left;
    bit first;
    logic en;
    logic dec;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encryption from reset values, byte extremes and single-byte messages.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);

    drain();
    apply_setting(1'b1, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC3, 1'b0);

    // A disabled byte inside a message must not advance the key state.
    drain();
    apply_setting(1'b0, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);

    drain();
    apply_setting(1'b1, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hA5, 1'b0);

    // A disabled byte that ends the message still clears the key state.
    drain();
    apply_setting(1'b0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    drain();
    apply_setting(1'b1, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);

    rnd_start = sent;
    msg_left = 0;
    first = 1'b1;
    while (sent - rnd_start < RANDOM_ITEMS) begin
      drain();
      if (first) begin
        // One message long enough for the step counter to wrap.
        en = 1'b1;
        dec = 1'($urandom_range(0, 1));
        phase_len = 320;
      end else begin
        en = ($urandom_range(0, 9) < 8);
        dec = 1'($urandom_range(0, 1));
        phase_len = $urandom_range(40, 150);
      end
      apply_setting(en, dec);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len; n++) begin
        if (msg_left == 0) begin
          if (first) msg_left = 300;
          else if ($urandom_range(0, 99) < 85) msg_left = $urandom_range(1, 24);
          else msg_left = $urandom_range(25, 80);
        end
        msg_left--;
        send_byte(pick_byte(), msg_left == 0);
      end
      first = 1'b0;
    end

    steady = 1'b0;
    drain();
    $display("Sent %0d bytes in %0d complete messages under %0d register settings.",
             sent, messages, settings_used);
    $display("Longest message was %0d bytes; encrypt, decrypt and bypass were all exercised.",
             longest);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
